FILE: design/assert_macros.svh
// Assertion macros for the RTL of the LED frame encoder, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define LPF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LPF_ASSERT(lbl, clk, rstn, prop)
`define LPF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: design/ledpwm_pkg.sv
// Types, constants and the gamma table of the LED frame encoder
`timescale 1ns / 1ps
package ledpwm_pkg;

  localparam int TRAILING_ZEROS = 41;
  localparam int BITS_PER_PIXEL = 24;
  localparam int CNT_W          = 6;
  localparam int GAIN_W         = 17;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CFG_DUTY_ONE   = 3'd0,
    CFG_DUTY_ZERO  = 3'd1,
    CFG_GAMMA_EN   = 3'd2,
    CFG_BRIGHTNESS = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        last;
  } pix_out_t;

  // stage control passed between pipeline stages
  typedef struct packed {
    logic  vld;
    func_e func;
  } stg_ctrl_t;

  typedef logic [255:0][15:0] lut_t;

  function automatic logic [63:0] pow5_q16(logic [63:0] y);
    logic [63:0] p;
    p = y;
    for (int k = 0; k < 4; k++) begin
      p = (p * y) >> 16;
    end
    return p;
  endfunction

  // Q8.8 table of 255*(c/255)^2.2, evaluated at elaboration
  function automatic lut_t build_gam_lut();
    lut_t        lut;
    logic [63:0] tq;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int c = 0; c < 256; c++) begin
      tq = (64'(c) * 64'd65536) / 64'd255;
      lo = 64'd0;
      hi = 64'd65536;
      for (int i = 0; i < 20; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (pow5_q16(mid) <= tq) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      lut[c] = 16'((64'(c) * 64'(c) * lo) / 64'd65280);
    end
    return lut;
  endfunction

  localparam lut_t GAM_LUT = build_gam_lut();

endpackage

FILE: design/ledpwm_lane.sv
// One color lane: gamma lookup and brightness scaling of a channel, or the raw channel when gamma is off
`timescale 1ns / 1ps
module ledpwm_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic                           gamma_en_i,
  input  logic [ledpwm_pkg::GAIN_W-1:0]  gain_i,
  input  logic [7:0]                     chan_i,
  output logic [8:0]                     scaled_o
);

  logic [15:0] lut_val;
  logic [32:0] prod;
  logic [8:0]  scaled_d;
  logic [8:0]  scaled_q;

  always_comb begin
    lut_val  = ledpwm_pkg::GAM_LUT[chan_i];
    prod     = 33'(lut_val) * 33'(gain_i);
    scaled_d = gamma_en_i ? prod[32:24] : {1'b0, chan_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

endmodule

FILE: design/ledpwm_merge.sv
// Merge stage: saturate the lane results and pack the GRB word
`timescale 1ns / 1ps
module ledpwm_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ledpwm_pkg::stg_ctrl_t s1_i,
  input  logic [8:0]            red_i,
  input  logic [8:0]            green_i,
  input  logic [8:0]            blue_i,
  input  logic                  take_i,
  output logic                  s1_adv_o,
  output ledpwm_pkg::stg_ctrl_t s2_o,
  output logic [23:0]           word_o
);

  ledpwm_pkg::stg_ctrl_t s2_d, s2_q;
  logic [23:0]           word_q;
  logic                  s2_ready;

  function automatic logic [7:0] sat8(logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

  always_comb begin
    s2_ready = !s2_q.vld || take_i;
    s1_adv_o = s1_i.vld && s2_ready;
    s2_d     = s2_q;
    if (s2_ready) begin
      s2_d = s1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '{vld: 1'b0, func: ledpwm_pkg::FUNC_START};
    end else begin
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_o) begin
      word_q <= {sat8(green_i), sat8(red_i), sat8(blue_i)};
    end
  end

  assign s2_o   = s2_q;
  assign word_o = word_q;

endmodule

FILE: design/ledpwm_ser.sv
// Serializer: emits one duty word per cycle from the loaded item while the output is not stalled
`timescale 1ns / 1ps
module ledpwm_ser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ledpwm_pkg::stg_ctrl_t s2_i,
  input  logic [23:0]           word_i,
  input  logic [15:0]           duty_one_i,
  input  logic [15:0]           duty_zero_i,
  input  logic                  out_stall_i,
  output logic                  take_o,
  output ledpwm_pkg::stg_ctrl_t ser_o,
  output logic                  out_valid_o,
  output ledpwm_pkg::pix_out_t  out_data_o
);

  ledpwm_pkg::stg_ctrl_t           st_d, st_q;
  logic [23:0]                     word_d, word_q;
  logic [ledpwm_pkg::CNT_W-1:0]    cnt_d, cnt_q;
  logic [ledpwm_pkg::CNT_W-1:0]    cnt_last;
  logic                            is_last;
  logic                            done;

  always_comb begin
    unique case (st_q.func)
      ledpwm_pkg::FUNC_START: cnt_last = '0;
      ledpwm_pkg::FUNC_PIXEL: cnt_last = ledpwm_pkg::CNT_W'(ledpwm_pkg::BITS_PER_PIXEL - 1);
      ledpwm_pkg::FUNC_END:   cnt_last = ledpwm_pkg::CNT_W'(ledpwm_pkg::TRAILING_ZEROS - 1);
      default:                cnt_last = '0;
    endcase
    is_last = (cnt_q == cnt_last);
    done    = st_q.vld && is_last && !out_stall_i;
    take_o  = !st_q.vld || done;

    st_d   = st_q;
    word_d = word_q;
    cnt_d  = cnt_q;
    if (take_o) begin
      // load the next transaction, or go empty
      st_d   = s2_i;
      word_d = word_i;
      cnt_d  = '0;
    end else if (st_q.vld && !out_stall_i) begin
      word_d = {word_q[22:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
    end

    out_valid_o = st_q.vld;
    out_data_o.last = is_last;
    if (st_q.func == ledpwm_pkg::FUNC_PIXEL) begin
      out_data_o.duty = word_q[23] ? duty_one_i : duty_zero_i;
    end else begin
      out_data_o.duty = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{vld: 1'b0, func: ledpwm_pkg::FUNC_START};
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign ser_o = st_q;

endmodule

FILE: design/led_pixel_pwm_frame_encoder_core.sv
// Top level: config registers, color lanes, merge stage and word serializer
// The first word of an item is registered through the stage-1, merge and serializer
// registers. The serializer emits one duty word per cycle while out_stall_i is low,
// so a pixel gives 24 words, a start 1 and an end 41; the lane and merge stages
// take the next item as the serializer drains. Unused code 3 is accepted and dropped.
// Reset (rst_ni low, async): pipeline empties, config returns to 60/30/off/65536.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module led_pixel_pwm_frame_encoder_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ledpwm_pkg::pix_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ledpwm_pkg::pix_out_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [16:0]          cfg_data_i
);

  logic [15:0]                   duty_one_q;
  logic [15:0]                   duty_zero_q;
  logic                          gamma_en_q;
  logic [ledpwm_pkg::GAIN_W-1:0] gain_q;

  ledpwm_pkg::stg_ctrl_t s1_d, s1_q;
  ledpwm_pkg::stg_ctrl_t s2;
  ledpwm_pkg::stg_ctrl_t ser_st;
  logic                  in_acc;
  logic                  in_keep;
  logic                  s1_adv;
  logic                  take;
  logic [8:0]            red_s, green_s, blue_s;
  logic [23:0]           word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_one_q  <= 16'd60;
      duty_zero_q <= 16'd30;
      gamma_en_q  <= 1'b0;
      gain_q      <= ledpwm_pkg::GAIN_W'(65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ledpwm_pkg::CFG_DUTY_ONE:   duty_one_q  <= cfg_data_i[15:0];
        ledpwm_pkg::CFG_DUTY_ZERO:  duty_zero_q <= cfg_data_i[15:0];
        ledpwm_pkg::CFG_GAMMA_EN:   gamma_en_q  <= cfg_data_i[0];
        ledpwm_pkg::CFG_BRIGHTNESS: gain_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_stall_o = s1_q.vld && !s1_adv;
    in_acc     = in_valid_i && !in_stall_o;
    // drop the unused function code at the door
    in_keep    = in_acc && (in_data_i.func != ledpwm_pkg::FUNC_RSVD);
    s1_d       = s1_q;
    if (in_keep) begin
      s1_d.vld  = 1'b1;
      s1_d.func = ledpwm_pkg::func_e'(in_data_i.func);
    end else if (s1_adv) begin
      s1_d.vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '{vld: 1'b0, func: ledpwm_pkg::FUNC_START};
    end else begin
      s1_q <= s1_d;
    end
  end

  ledpwm_lane u_lane_r (
    .clk_i, .en_i(in_keep), .gamma_en_i(gamma_en_q), .gain_i(gain_q),
    .chan_i(in_data_i.red), .scaled_o(red_s)
  );

  ledpwm_lane u_lane_g (
    .clk_i, .en_i(in_keep), .gamma_en_i(gamma_en_q), .gain_i(gain_q),
    .chan_i(in_data_i.green), .scaled_o(green_s)
  );

  ledpwm_lane u_lane_b (
    .clk_i, .en_i(in_keep), .gamma_en_i(gamma_en_q), .gain_i(gain_q),
    .chan_i(in_data_i.blue), .scaled_o(blue_s)
  );

  ledpwm_merge u_merge (
    .clk_i, .rst_ni, .s1_i(s1_q), .red_i(red_s), .green_i(green_s), .blue_i(blue_s),
    .take_i(take), .s1_adv_o(s1_adv), .s2_o(s2), .word_o(word)
  );

  ledpwm_ser u_ser (
    .clk_i, .rst_ni, .s2_i(s2), .word_i(word), .duty_one_i(duty_one_q),
    .duty_zero_i(duty_zero_q), .out_stall_i, .take_o(take), .ser_o(ser_st),
    .out_valid_o, .out_data_o
  );

  `LPF_ASSERT(a_gap_words_zero, clk_i, rst_ni, (out_valid_o && ser_st.func != ledpwm_pkg::FUNC_PIXEL) |-> (out_data_o.duty == 16'd0))
  `LPF_ASSERT(a_stall_needs_s1, clk_i, rst_ni, in_stall_o |-> s1_q.vld)
  `LPF_ASSERT(a_start_single, clk_i, rst_ni, (out_valid_o && ser_st.func == ledpwm_pkg::FUNC_START) |-> out_data_o.last)

endmodule
